[rtl/lat_pkg.sv]
// Shared widths, codes and types for the life automaton torus step block.
`timescale 1ns / 1ps

package lat_pkg;

    // Field widths of the item, result and configuration words
    localparam int MODE_W     = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int THR_W      = 4;
    localparam int SIZE_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Default store dimensions
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OVERCROWD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ISOLATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 3'd4;

    // Configuration reset values
    localparam logic [THR_W-1:0]  RST_OVERCROWD = 4'd4;
    localparam logic [THR_W-1:0]  RST_ISOLATION = 4'd1;
    localparam logic [THR_W-1:0]  RST_BIRTH     = 4'd3;
    localparam logic [SIZE_W-1:0] RST_ROWS      = 7'd64;
    localparam logic [SIZE_W-1:0] RST_COLS      = 7'd64;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_ADV,
        ST_TAIL
    } t_state;

endpackage

[rtl/lat_ifs.sv]
// Valid/ready channel interfaces for items, results and configuration writes.
`timescale 1ns / 1ps

interface lat_in_if;
    import lat_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              alive_in;
    modport source (output valid, mode, row, col, alive_in, input ready);
    modport sink   (input valid, mode, row, col, alive_in, output ready);
endinterface

interface lat_out_if;
    logic valid;
    logic ready;
    logic cell_alive;
    modport source (output valid, cell_alive, input ready);
    modport sink   (input valid, cell_alive, output ready);
endinterface

interface lat_cfg_if;
    import lat_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/life_automaton_torus_step.sv]
// Top level: toroidal life automaton with a row-wide grid memory and sweep sequencer.
`timescale 1ns / 1ps

// The grid lives in one synchronous memory of MAX_ROWS rows, MAX_COLS cells wide,
// and every input word gives exactly one result word. After reset a clearing pass
// writes MAX_ROWS dead rows, one per cycle, and no word is accepted until it ends;
// configuration writes are taken at any time. A cell write or read reads the row,
// then writes it back or picks the bit; an unused mode is answered from idle; an
// advance sweeps h rows, h being the clamped row count: the sweep reads one row per
// cycle over the single read port, computes a whole row of new cells per cycle and
// writes it back, keeping the old row above, the current row and the original top
// row in three row registers. A new word is accepted only in the idle state and
// when the output register is empty or hands its word over in the same cycle.
module life_automaton_torus_step #(
    parameter int MAX_ROWS = lat_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lat_pkg::DEF_MAX_COLS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lat_in_if.sink          i_in,
    lat_out_if.source       o_out,
    lat_cfg_if.sink         i_cfg
);
    import lat_pkg::*;

    localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int RXW = RAW + ROW_W;
    localparam int CXW = CAW + COL_W;

    // Grid memory and its read register
    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_COLS-1:0] r_mem_q;

    // Configuration registers
    logic [THR_W-1:0]  r_over;
    logic [THR_W-1:0]  r_iso;
    logic [THR_W-1:0]  r_birth;
    logic [SIZE_W-1:0] r_rows;
    logic [SIZE_W-1:0] r_cols;

    // Sequencer and captured item
    t_state             r_state;
    t_state             n_state;
    logic [RCW-1:0]     r_cnt;
    logic               r_ret_vld;
    logic [RCW-1:0]     r_ret_k;
    logic [MODE_W-1:0]  r_mode;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic               r_alive;

    // Sweep row registers: row above, current row, original top row
    logic [MAX_COLS-1:0] r_up;
    logic [MAX_COLS-1:0] r_cur;
    logic [MAX_COLS-1:0] r_first;

    // Result register
    logic r_out_valid;
    logic r_out_data;

    // Control and datapath signals
    logic                in_ready;
    logic                in_acc;
    logic                done;
    logic                result;
    logic                rd_en;
    logic [RAW-1:0]      rd_addr;
    logic                wr_en;
    logic [RAW-1:0]      wr_addr;
    logic [MAX_COLS-1:0] wr_data;
    logic [RCW-1:0]      h;
    logic [RCW-1:0]      h_m1;
    logic [RCW-1:0]      cnt_m1;
    logic [RCW-1:0]      k_m2;
    logic [CCW-1:0]      w;
    logic [CCW-1:0]      w_m1;
    logic [RXW-1:0]      in_row_x;
    logic [RXW-1:0]      r_row_x;
    logic [CXW-1:0]      r_col_x;
    logic [RAW-1:0]      in_row_addr;
    logic [RAW-1:0]      r_row_addr;
    logic [CAW-1:0]      r_col_idx;
    logic                r_inside;
    logic [MAX_COLS-1:0] dn_row;
    logic [MAX_COLS-1:0] row_new;
    logic [MAX_COLS-1:0] cell_row;

    // Handshakes
    assign in_ready         = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign in_acc           = i_in.valid && in_ready;
    assign i_in.ready       = in_ready;
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.cell_alive = r_out_data;

    // Clamp the torus size to 1..MAX
    always_comb begin
        if (r_rows == '0) begin
            h = RCW'(1);
        end else if (32'(r_rows) > 32'(MAX_ROWS)) begin
            h = RCW'(MAX_ROWS);
        end else begin
            h = RCW'(r_rows);
        end
        if (r_cols == '0) begin
            w = CCW'(1);
        end else if (32'(r_cols) > 32'(MAX_COLS)) begin
            w = CCW'(MAX_COLS);
        end else begin
            w = CCW'(r_cols);
        end
    end

    assign h_m1   = h - RCW'(1);
    assign w_m1   = w - CCW'(1);
    assign cnt_m1 = r_cnt - RCW'(1);
    assign k_m2   = r_ret_k - RCW'(2);

    // Map item addresses onto store index widths
    assign in_row_x    = RXW'(i_in.row);
    assign r_row_x     = RXW'(r_row);
    assign r_col_x     = CXW'(r_col);
    assign in_row_addr = in_row_x[RAW-1:0];
    assign r_row_addr  = r_row_x[RAW-1:0];
    assign r_col_idx   = r_col_x[CAW-1:0];
    assign r_inside    = (32'(r_row) < 32'(MAX_ROWS)) && (32'(r_col) < 32'(MAX_COLS));

    // Row below comes from the memory, or the saved top row for the last row
    assign dn_row = r_ret_vld ? r_mem_q : r_first;

    // Compute one new row from three old rows, wrapping columns at w
    always_comb begin
        logic [CAW-1:0] lf;
        logic [CAW-1:0] rt;
        logic [3:0]     nb;
        lf      = '0;
        rt      = '0;
        nb      = '0;
        row_new = r_cur;
        for (int c = 0; c < MAX_COLS; c++) begin
            lf = (c == 0) ? w_m1[CAW-1:0] : CAW'(c - 1);
            rt = ((c == MAX_COLS - 1) || (32'(c) == 32'(w_m1))) ? '0 : CAW'(c + 1);
            nb = 4'(r_up[lf]) + 4'(r_up[c]) + 4'(r_up[rt])
               + 4'(r_cur[lf]) + 4'(r_cur[rt])
               + 4'(dn_row[lf]) + 4'(dn_row[c]) + 4'(dn_row[rt]);
            if (32'(c) < 32'(w)) begin
                if (r_cur[c]) begin
                    row_new[c] = !((nb >= r_over) || (nb <= r_iso));
                end else begin
                    row_new[c] = (nb == r_birth);
                end
            end
        end
    end

    // Replace the addressed bit for a cell write
    always_comb begin
        cell_row            = r_mem_q;
        cell_row[r_col_idx] = r_alive;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_cnt == RCW'(MAX_ROWS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.mode == MODE_WRITE || i_in.mode == MODE_READ) begin
                        n_state = ST_CELL;
                    end else if (i_in.mode == MODE_ADVANCE) begin
                        n_state = ST_ADV;
                    end
                end
            end
            ST_CELL: n_state = ST_IDLE;
            ST_ADV: begin
                if (r_cnt == h) n_state = ST_TAIL;
            end
            ST_TAIL: begin
                if (!r_ret_vld) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory accesses and completion
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = row_new;
        done    = 1'b0;
        result  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt[RAW-1:0];
                wr_data = '0;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.mode == MODE_WRITE || i_in.mode == MODE_READ) begin
                        rd_en   = 1'b1;
                        rd_addr = in_row_addr;
                    end else if (i_in.mode != MODE_ADVANCE) begin
                        done = 1'b1;
                    end
                end
            end
            ST_CELL: begin
                done = 1'b1;
                if (r_inside) begin
                    if (r_mode == MODE_WRITE) begin
                        wr_en   = 1'b1;
                        wr_addr = r_row_addr;
                        wr_data = cell_row;
                        result  = r_alive;
                    end else begin
                        result  = r_mem_q[r_col_idx];
                    end
                end
            end
            ST_ADV: begin
                rd_en   = 1'b1;
                rd_addr = (r_cnt == '0) ? h_m1[RAW-1:0] : cnt_m1[RAW-1:0];
                if (r_ret_vld && r_ret_k >= RCW'(2)) begin
                    wr_en   = 1'b1;
                    wr_addr = k_m2[RAW-1:0];
                end
            end
            ST_TAIL: begin
                if (r_ret_vld) begin
                    if (r_ret_k >= RCW'(2)) begin
                        wr_en   = 1'b1;
                        wr_addr = k_m2[RAW-1:0];
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = h_m1[RAW-1:0];
                    done    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Grid memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_mem_q <= mem[rd_addr];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_over  <= RST_OVERCROWD;
            r_iso   <= RST_ISOLATION;
            r_birth <= RST_BIRTH;
            r_rows  <= RST_ROWS;
            r_cols  <= RST_COLS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_OVERCROWD: r_over  <= i_cfg.data[THR_W-1:0];
                CFG_ISOLATION: r_iso   <= i_cfg.data[THR_W-1:0];
                CFG_BIRTH:     r_birth <= i_cfg.data[THR_W-1:0];
                CFG_ROWS:      r_rows  <= i_cfg.data[SIZE_W-1:0];
                CFG_COLS:      r_cols  <= i_cfg.data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_ret_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret_vld <= (r_state == ST_ADV);
            if (r_state == ST_CLEAR || r_state == ST_ADV) begin
                r_cnt <= r_cnt + RCW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the item, track sweep returns and shift the row window
    always_ff @(posedge i_clk) begin
        r_ret_k <= r_cnt;
        if (done) r_out_data <= result;
        if (in_acc) begin
            r_mode  <= i_in.mode;
            r_row   <= i_in.row;
            r_col   <= i_in.col;
            r_alive <= i_in.alive_in;
        end
        if (r_ret_vld) begin
            if (r_ret_k == '0) begin
                r_up <= r_mem_q;
            end else if (r_ret_k == RCW'(1)) begin
                r_cur   <= r_mem_q;
                r_first <= r_mem_q;
            end else begin
                r_up  <= r_cur;
                r_cur <= r_mem_q;
            end
        end
    end

endmodule

[tb/tb_life_automaton_torus_step.sv]
// Self-checking testbench for the life automaton torus step block.
`timescale 1ns / 1ps

module tb_life_automaton_torus_step;
    import lat_pkg::*;

    localparam int GRID_ROWS   = DEF_MAX_ROWS;
    localparam int GRID_COLS   = DEF_MAX_COLS;
    localparam int MAX_GAP     = 13;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 80;
    localparam int ITEM_TARGET = 650;

    // Codes the package leaves unnamed: the unused mode and an unused register slot
    localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              alive_in;
    } t_cell_cmd;

    // Shadow grid and rule registers; predicts one cell word per accepted item word
    class life_board;
        bit [GRID_COLS-1:0] grid [GRID_ROWS];
        int unsigned        overcrowd;
        int unsigned        isolation;
        int unsigned        birth;
        int unsigned        rows_used;
        int unsigned        cols_used;
        bit                 expected_cells [$];
        int                 errors;
        int                 items_taken;

        function new();
            foreach (grid[r]) grid[r] = '0;
            overcrowd   = 32'(RST_OVERCROWD);
            isolation   = 32'(RST_ISOLATION);
            birth       = 32'(RST_BIRTH);
            rows_used   = 32'(RST_ROWS);
            cols_used   = 32'(RST_COLS);
            errors      = 0;
            items_taken = 0;
        endfunction

        // Mirror one register write; sizes clamp to 1..store size
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OVERCROWD: overcrowd = 32'(data[THR_W-1:0]);
                CFG_ISOLATION: isolation = 32'(data[THR_W-1:0]);
                CFG_BIRTH:     birth     = 32'(data[THR_W-1:0]);
                CFG_ROWS: begin
                    rows_used = (data == 0) ? 1 : (data > GRID_ROWS) ? GRID_ROWS : 32'(data);
                end
                CFG_COLS: begin
                    cols_used = (data == 0) ? 1 : (data > GRID_COLS) ? GRID_COLS : 32'(data);
                end
                default: ;
            endcase
        endfunction

        // Advance the torus one generation from a frozen copy of the grid
        function void step_generation();
            bit [GRID_COLS-1:0] prev [GRID_ROWS];
            int                 rr [3];
            int                 cc [3];
            int                 n;
            prev = grid;
            for (int r = 0; r < rows_used; r++) begin
                rr[0] = (r == 0) ? rows_used - 1 : r - 1;
                rr[1] = r;
                rr[2] = (r == rows_used - 1) ? 0 : r + 1;
                for (int c = 0; c < cols_used; c++) begin
                    cc[0] = (c == 0) ? cols_used - 1 : c - 1;
                    cc[1] = c;
                    cc[2] = (c == cols_used - 1) ? 0 : c + 1;
                    // repeated wrapped positions count once per occurrence
                    n = 0;
                    for (int i = 0; i < 3; i++) begin
                        for (int j = 0; j < 3; j++) begin
                            if (i != 1 || j != 1) n += int'(prev[rr[i]][cc[j]]);
                        end
                    end
                    if (prev[r][c]) begin
                        if (n >= overcrowd || n <= isolation) grid[r][c] = 1'b0;
                    end else if (n == birth) begin
                        grid[r][c] = 1'b1;
                    end
                end
            end
        endfunction

        // Note an accepted item word and queue the cell word it must produce
        function void take_item(t_cell_cmd cmd);
            bit predicted;
            predicted = 1'b0;
            case (cmd.mode)
                MODE_WRITE: begin
                    grid[cmd.row][cmd.col] = cmd.alive_in;
                    predicted = cmd.alive_in;
                end
                MODE_READ:    predicted = grid[cmd.row][cmd.col];
                MODE_ADVANCE: step_generation();
                default: ;
            endcase
            expected_cells = {expected_cells, predicted};
            items_taken++;
        endfunction

        // Compare a returned cell word with the oldest prediction
        function void check_cell(logic actual);
            bit want;
            if (expected_cells.size() == 0) begin
                $error("cell_alive: expected nothing, actual %0b", actual);
                errors++;
                return;
            end
            want = expected_cells.pop_front();
            if (actual !== want) begin
                $error("cell_alive: expected %0b, actual %0b", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    bit        gaps_on;
    life_board board;

    lat_in_if  item_ch ();
    lat_out_if cell_ch ();
    lat_cfg_if reg_ch ();

    life_automaton_torus_step #(
        .MAX_ROWS (GRID_ROWS),
        .MAX_COLS (GRID_COLS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_ch),
        .o_out   (cell_ch),
        .i_cfg   (reg_ch)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Check every cell word taken by the receiver
    always @(posedge i_clk) begin
        if (i_rst_n && cell_ch.valid && cell_ch.ready) board.check_cell(cell_ch.cell_alive);
    end

    // Receiver: stall a random number of cycles before taking each word
    initial begin
        int stall;
        cell_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                cell_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            cell_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!cell_ch.valid) @(posedge i_clk);
        end
    end

    // Watchdog: end the run once no channel has moved a word for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (item_ch.valid && item_ch.ready) ||
                (cell_ch.valid && cell_ch.ready) || (reg_ch.valid && reg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one item word after a random gap; leave valid high on return
    task automatic send_cell(input logic [MODE_W-1:0] mode, input int row, input int col,
                             input bit alive);
        int        gap;
        t_cell_cmd cmd;
        gap          = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        cmd.mode     = mode;
        cmd.row      = row[ROW_W-1:0];
        cmd.col      = col[COL_W-1:0];
        cmd.alive_in = alive;
        @(negedge i_clk);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.mode     <= cmd.mode;
        item_ch.row      <= cmd.row;
        item_ch.col      <= cmd.col;
        item_ch.alive_in <= cmd.alive_in;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        board.take_item(cmd);
    endtask

    // Occasionally slip in an arbitrary word, unused mode and stray cells included
    task automatic maybe_stray();
        if ($urandom_range(0, 5) == 0)
            send_cell(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                      $urandom_range(0, 63), 1'($urandom_range(0, 1)));
    endtask

    // Drop valid and hold until every predicted cell word has come back
    task automatic pause_items();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (board.expected_cells.size() != 0) @(posedge i_clk);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= data;
        @(posedge i_clk);
        while (!reg_ch.ready) @(posedge i_clk);
        board.set_reg(idx, data);
    endtask

    // Load the full rule set and torus size, then release the register channel
    task automatic set_rules(input logic [CFG_DATA_W-1:0] ov, input logic [CFG_DATA_W-1:0] iso,
                             input logic [CFG_DATA_W-1:0] bi, input logic [CFG_DATA_W-1:0] rows,
                             input logic [CFG_DATA_W-1:0] cols);
        write_reg(CFG_OVERCROWD, ov);
        write_reg(CFG_ISOLATION, iso);
        write_reg(CFG_BIRTH, bi);
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_COLS, cols);
        @(negedge i_clk);
        reg_ch.valid <= 1'b0;
    endtask

    // One random phase: pick rules and size, seed a window, then advance and probe it
    task automatic run_colony(input int phase);
        logic [CFG_DATA_W-1:0] rows_d, cols_d, ov, iso, bi;
        int h, w, r0, c0, sh, sw, rounds, peeks;
        if (phase == 0) begin
            // oversize torus and every threshold at its top
            rows_d = 7'd127;
            cols_d = 7'd127;
            ov     = 7'h7F;
            iso    = 7'h7F;
            bi     = 7'h7F;
        end else if (phase == 1) begin
            // zero height, overcrowding at zero kills every live cell
            rows_d = 7'd0;
            cols_d = 7'd2;
            ov     = 7'h00;
            iso    = 7'h08;
            bi     = 7'h08;
        end else begin
            rows_d = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(60, 127))
                                                 : CFG_DATA_W'($urandom_range(1, 12));
            cols_d = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(60, 127))
                                                 : CFG_DATA_W'($urandom_range(1, 12));
            if ($urandom_range(0, 2) != 0) begin
                ov  = {3'($urandom_range(0, 7)), RST_OVERCROWD};
                iso = {3'($urandom_range(0, 7)), RST_ISOLATION};
                bi  = {3'($urandom_range(0, 7)), RST_BIRTH};
            end else begin
                ov  = CFG_DATA_W'($urandom_range(0, 127));
                iso = CFG_DATA_W'($urandom_range(0, 127));
                bi  = CFG_DATA_W'($urandom_range(0, 127));
            end
        end
        pause_items();
        set_rules(ov, iso, bi, rows_d, cols_d);
        gaps_on = ($urandom_range(0, 3) != 0);

        h  = board.rows_used;
        w  = board.cols_used;
        r0 = $urandom_range(0, h - 1);
        c0 = $urandom_range(0, w - 1);
        sh = $urandom_range(1, (h < 6) ? h : 6);
        sw = $urandom_range(1, (w < 6) ? w : 6);

        // seed a small window of the torus, wrapping at its edges
        repeat ($urandom_range(4, 14)) begin
            send_cell(MODE_WRITE, (r0 + $urandom_range(0, sh - 1)) % h,
                      (c0 + $urandom_range(0, sw - 1)) % w, 1'($urandom_range(0, 1)));
            maybe_stray();
        end
        // advance and probe the same window
        rounds = $urandom_range(1, 3);
        repeat (rounds) begin
            send_cell(MODE_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                      1'($urandom_range(0, 1)));
            peeks = $urandom_range(2, 5);
            repeat (peeks) begin
                send_cell(MODE_READ, (r0 + $urandom_range(0, sh - 1)) % h,
                          (c0 + $urandom_range(0, sw - 1)) % w, 1'($urandom_range(0, 1)));
                maybe_stray();
            end
        end
    endtask

    // Main sequence: reset, directed cases, random phases, drain
    initial begin
        i_rst_n          = 1'b0;
        item_ch.valid    = 1'b0;
        item_ch.mode     = MODE_READ;
        item_ch.row      = '0;
        item_ch.col      = '0;
        item_ch.alive_in = 1'b0;
        reg_ch.valid     = 1'b0;
        reg_ch.index     = CFG_OVERCROWD;
        reg_ch.data      = '0;
        gaps_on          = 1'b1;
        board            = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset rules on the full torus: cleared store, blinker across the wrap corner
        send_cell(MODE_READ, 63, 63, 1'b1);
        send_cell(MODE_WRITE, 0, 63, 1'b1);
        send_cell(MODE_WRITE, 0, 0, 1'b1);
        send_cell(MODE_WRITE, 0, 1, 1'b1);
        send_cell(MODE_WRITE, 63, 0, 1'b0);
        send_cell(MODE_SPARE, 63, 63, 1'b1);
        send_cell(MODE_ADVANCE, 0, 0, 1'b0);
        send_cell(MODE_READ, 63, 0, 1'b0);
        send_cell(MODE_READ, 0, 0, 1'b0);
        send_cell(MODE_READ, 1, 0, 1'b0);
        send_cell(MODE_READ, 0, 63, 1'b0);

        // One-cell torus: the cell sees itself eight times; birth on zero neighbors
        pause_items();
        write_reg(CFG_SPARE, 7'h55);
        set_rules(7'h79, 7'h70, 7'h40, 7'd0, 7'd0);
        send_cell(MODE_WRITE, 0, 0, 1'b1);
        send_cell(MODE_WRITE, 3, 3, 1'b1);
        send_cell(MODE_ADVANCE, 63, 63, 1'b1);
        send_cell(MODE_READ, 0, 0, 1'b0);
        send_cell(MODE_READ, 3, 3, 1'b0);
        send_cell(MODE_WRITE, 0, 0, 1'b0);
        send_cell(MODE_ADVANCE, 0, 0, 1'b0);
        send_cell(MODE_READ, 0, 0, 1'b0);
        send_cell(MODE_READ, 0, 1, 1'b0);

        for (int phase = 0; board.items_taken < ITEM_TARGET; phase++) run_colony(phase);

        // Drain and give stray words time to show up
        pause_items();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
rtl/lat_pkg.sv
rtl/lat_ifs.sv
rtl/life_automaton_torus_step.sv
tb/tb_life_automaton_torus_step.sv
